/* rtl/core/grid_root_condition_merge_defines.svh */
// Assertion macros used by the checker file.
`ifndef GRID_ROOT_CONDITION_MERGE_DEFINES_SVH
`define GRID_ROOT_CONDITION_MERGE_DEFINES_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define GRCM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define GRCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/grcm_pkg.sv */
`default_nettype none

package grcm_pkg;

   localparam int POINTS     = 4096;
   localparam int COUNT_BITS = 16;
   localparam int ADDR_BITS  = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int POINT_BITS = 12;
   localparam int NTYPES     = 4;
   localparam int COND_BITS  = 2;
   localparam int VALUE_BITS = 32;

   // operation codes
   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // condition types
   localparam logic [COND_BITS-1:0] COND_DIR  = 2'd0;
   localparam logic [COND_BITS-1:0] COND_NEU  = 2'd1;
   localparam logic [COND_BITS-1:0] COND_ATM  = 2'd2;
   localparam logic [COND_BITS-1:0] COND_NONE = 2'd3;

   // control register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATM_ADD         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIORITY_FIRST  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIORITY_SECOND = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIORITY_THIRD  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIORITY_FOURTH = 3'd4;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0]        count_type;
   typedef logic [COND_BITS-1:0]         cond_type;

   localparam value_type CODE_MAX   = 32'sh7FFF_FFFF;
   localparam value_type CODE_MIN   = 32'sh8000_0000;
   localparam value_type VALUE_ZERO = 32'sh0000_0000;
   localparam count_type COUNT_FULL = '1;

   typedef struct packed {
      logic                  op;
      logic [POINT_BITS-1:0] point;
      cond_type              condition;
      value_type             uptake;
      value_type             p_zero;
      value_type             p_two_high;
      value_type             p_two_low;
      value_type             p_three;
      value_type             r_two_high;
      value_type             r_two_low;
      value_type             beta;
   } grcm_req_type;

   typedef struct packed {
      cond_type  main_condition;
      value_type dir_value;
      value_type neu_value;
      value_type atm_value;
      value_type best_p_zero;
      value_type best_p_two_high;
      value_type best_p_two_low;
      value_type best_p_three;
      value_type best_r_two_high;
      value_type best_r_two_low;
   } grcm_rsp_type;

   // one point's merge record, as held in the table memory
   typedef struct packed {
      count_type [NTYPES-1:0] counts;
      value_type              dir;
      value_type              neu;
      value_type              atm;
      value_type              p_zero;
      value_type              p_two_high;
      value_type              p_two_low;
      value_type              p_three;
      value_type              r_two_high;
      value_type              r_two_low;
   } grcm_entry_type;

   localparam int ENTRY_BITS = $bits(grcm_entry_type);

   localparam grcm_entry_type ENTRY_RESET = '{
      counts:     '0,
      dir:        CODE_MAX,
      neu:        VALUE_ZERO,
      atm:        VALUE_ZERO,
      p_zero:     CODE_MIN,
      p_two_high: CODE_MAX,
      p_two_low:  CODE_MAX,
      p_three:    CODE_MAX,
      r_two_high: VALUE_ZERO,
      r_two_low:  VALUE_ZERO
   };

   // signed add, clamped to the 32-bit range
   function automatic value_type sat_add(input value_type a, input value_type b);
      logic [VALUE_BITS:0] sum;
      sum = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
      if (sum[VALUE_BITS] != sum[VALUE_BITS-1]) begin
         sat_add = sum[VALUE_BITS] ? CODE_MIN : CODE_MAX;
      end else begin
         sat_add = sum[VALUE_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/core/grid_root_condition_merge.sv */
// Root condition merge table, one record per grid point.
// Input channel req_*: valid/ready beats. An accumulate beat (op 0) merges one
// root entry into its point; a read beat (op 1) returns the point's values and
// main condition on rsp_* and clears the point. Accumulates yield no rsp beat.
// Control registers (atm_add, tie priority order) are written through csr_*;
// the user must write them only while the block is idle, which the block
// itself does not enforce. A read beat passes the merge stage register and
// then the output register before its rsp beat shows. Accumulate beats go
// one per cycle while req_ready is high; a read beat holds off the following
// beat. The table is a single-port-write, single-port-read memory with a
// registered read; the merge and write-back happen in the cycle after the
// read, and a forward register covers a beat that hits the point written
// just before it. Reset: synchronous, active high. After reset the block
// sweeps the table to its cleared state, one point a cycle over all POINTS
// (4096) points, with req_ready low; csr writes are taken during the sweep.
// Stall: a rsp beat waits in the output register while rsp_ready is low;
// req_ready drops until that register frees up.
`default_nettype none

module grid_root_condition_merge
   import grcm_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire grcm_req_type              req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output grcm_rsp_type                   rsp_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // control registers
   logic     atm_add_ff, atm_add_in;
   cond_type prio_ff [NTYPES];
   cond_type prio_in [NTYPES];

   // clearing sweep
   logic [ADDR_BITS-1:0] clear_addr_ff, clear_addr_in;
   logic                 cleared_ff, cleared_in;

   // merge stage: the beat whose table word arrives this cycle
   logic         s1_valid_ff, s1_valid_in;
   logic         s1_in_range_ff, s1_in_range_in;
   grcm_req_type s1_req_ff, s1_req_in;

   // last item write-back, for a beat that reads the same point right after
   logic                 fwd_valid_ff, fwd_valid_in;
   logic [ADDR_BITS-1:0] fwd_addr_ff, fwd_addr_in;
   grcm_entry_type       fwd_entry_ff, fwd_entry_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   grcm_rsp_type rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 req_in_range;
   logic [ADDR_BITS-1:0] req_addr;
   logic [ADDR_BITS-1:0] s1_addr;
   logic                 s1_is_read;
   logic [ENTRY_BITS-1:0] ram_rdata;
   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   grcm_entry_type        ram_wr_data;
   grcm_entry_type        cur_entry;
   grcm_entry_type        merged;
   count_type             cur_count;
   count_type             best_count;
   cond_type              main_cond;
   logic                  main_found;

   // ------------------------------------------------------------------
   // input side
   // ------------------------------------------------------------------
   assign s1_is_read = s1_valid_ff && (s1_req_ff.op == OP_READ);

   // hold off a beat behind a read, and while the output register stays full
   assign req_ready  = cleared_ff && !s1_is_read && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   assign req_addr     = ADDR_BITS'(req_data.point);
   assign req_in_range = 32'(req_data.point) < 32'(POINTS);
   assign s1_addr      = ADDR_BITS'(s1_req_ff.point);

   always_comb begin
      s1_valid_in    = req_accept;
      s1_req_in      = req_accept ? req_data : s1_req_ff;
      s1_in_range_in = req_accept ? req_in_range : s1_in_range_ff;
   end

   // ------------------------------------------------------------------
   // table memory
   // ------------------------------------------------------------------
   grcm_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_rdata)
   );

   // pick the live record: forward the previous write-back on an address hit,
   // and treat a point beyond the table as a cleared record
   always_comb begin
      if (!s1_in_range_ff) begin
         cur_entry = ENTRY_RESET;
      end else if (fwd_valid_ff && (fwd_addr_ff == s1_addr)) begin
         cur_entry = fwd_entry_ff;
      end else begin
         cur_entry = grcm_entry_type'(ram_rdata);
      end
   end

   // ------------------------------------------------------------------
   // merge of one root entry
   // ------------------------------------------------------------------
   always_comb begin
      merged    = cur_entry;
      cur_count = cur_entry.counts[s1_req_ff.condition];
      if (cur_count != COUNT_FULL) begin
         merged.counts[s1_req_ff.condition] = cur_count + count_type'(1);
      end
      case (s1_req_ff.condition)
         COND_DIR: begin
            if ($signed(cur_entry.dir) > $signed(s1_req_ff.uptake)) begin
               merged.dir = s1_req_ff.uptake;
            end
         end
         COND_NEU: begin
            merged.neu = sat_add(cur_entry.neu, s1_req_ff.uptake);
         end
         COND_ATM: begin
            if ($signed(cur_entry.p_zero) < $signed(s1_req_ff.p_zero)) begin
               merged.p_zero = s1_req_ff.p_zero;
            end
            if ($signed(cur_entry.p_three) > $signed(s1_req_ff.p_three)) begin
               merged.p_three = s1_req_ff.p_three;
            end
            // replace each P2 together with its rate
            if ($signed(cur_entry.p_two_high) > $signed(s1_req_ff.p_two_high)) begin
               merged.p_two_high = s1_req_ff.p_two_high;
               merged.r_two_high = s1_req_ff.r_two_high;
            end
            if ($signed(cur_entry.p_two_low) > $signed(s1_req_ff.p_two_low)) begin
               merged.p_two_low = s1_req_ff.p_two_low;
               merged.r_two_low = s1_req_ff.r_two_low;
            end
            if (atm_add_ff) begin
               merged.atm = sat_add(cur_entry.atm, s1_req_ff.beta);
            end else if ($signed(cur_entry.atm) < $signed(s1_req_ff.beta)) begin
               merged.atm = s1_req_ff.beta;
            end
         end
         default: begin
            // none: only its count moves
         end
      endcase
   end

   // ------------------------------------------------------------------
   // main condition: highest count, ties settled by the priority order
   // ------------------------------------------------------------------
   always_comb begin
      best_count = cur_entry.counts[COND_DIR];
      if (cur_entry.counts[COND_NEU] > best_count) begin
         best_count = cur_entry.counts[COND_NEU];
      end
      if (cur_entry.counts[COND_ATM] > best_count) begin
         best_count = cur_entry.counts[COND_ATM];
      end
      main_cond  = COND_NONE;
      main_found = 1'b0;
      if (best_count != '0) begin
         for (int k = 0; k < NTYPES; k++) begin
            if (!main_found && (prio_ff[k] != COND_NONE) &&
                (cur_entry.counts[prio_ff[k]] == best_count)) begin
               main_cond  = prio_ff[k];
               main_found = 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // write-back: sweep after reset, then one item write per in-range merge beat
   // ------------------------------------------------------------------
   always_comb begin
      if (!cleared_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = ENTRY_RESET;
      end else begin
         ram_wr_en   = s1_valid_ff && s1_in_range_ff;
         ram_wr_addr = s1_addr;
         ram_wr_data = s1_is_read ? ENTRY_RESET : merged;
      end
      clear_addr_in = cleared_ff ? clear_addr_ff : clear_addr_ff + ADDR_BITS'(1);
      cleared_in    = cleared_ff || (clear_addr_ff == ADDR_BITS'(POINTS - 1));
      fwd_valid_in  = (cleared_ff && s1_valid_ff && s1_in_range_ff) || fwd_valid_ff;
      fwd_addr_in   = ram_wr_en && cleared_ff ? ram_wr_addr : fwd_addr_ff;
      fwd_entry_in  = ram_wr_en && cleared_ff ? ram_wr_data : fwd_entry_ff;
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = s1_is_read || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_data_ff;
      if (s1_is_read) begin
         rsp_data_in.main_condition  = main_cond;
         rsp_data_in.dir_value       = cur_entry.dir;
         rsp_data_in.neu_value       = cur_entry.neu;
         rsp_data_in.atm_value       = cur_entry.atm;
         rsp_data_in.best_p_zero     = cur_entry.p_zero;
         rsp_data_in.best_p_two_high = cur_entry.p_two_high;
         rsp_data_in.best_p_two_low  = cur_entry.p_two_low;
         rsp_data_in.best_p_three    = cur_entry.p_three;
         rsp_data_in.best_r_two_high = cur_entry.r_two_high;
         rsp_data_in.best_r_two_low  = cur_entry.r_two_low;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // control register writes
   // ------------------------------------------------------------------
   always_comb begin
      atm_add_in = atm_add_ff;
      prio_in    = prio_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ATM_ADD:         atm_add_in = csr_wdata[0];
            CSR_PRIORITY_FIRST:  prio_in[0] = csr_wdata;
            CSR_PRIORITY_SECOND: prio_in[1] = csr_wdata;
            CSR_PRIORITY_THIRD:  prio_in[2] = csr_wdata;
            CSR_PRIORITY_FOURTH: prio_in[3] = csr_wdata;
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         atm_add_ff    <= 1'b0;
         prio_ff[0]    <= COND_DIR;
         prio_ff[1]    <= COND_NEU;
         prio_ff[2]    <= COND_ATM;
         prio_ff[3]    <= COND_NONE;
         clear_addr_ff <= '0;
         cleared_ff    <= 1'b0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         atm_add_ff    <= atm_add_in;
         prio_ff       <= prio_in;
         clear_addr_ff <= clear_addr_in;
         cleared_ff    <= cleared_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff      <= s1_req_in;
      s1_in_range_ff <= s1_in_range_in;
      fwd_addr_ff    <= fwd_addr_in;
      fwd_entry_ff   <= fwd_entry_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* rtl/core/grcm_ram.sv */
`default_nettype none

module grcm_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/grcm_checker.sv */
`default_nettype none
`include "grid_root_condition_merge_defines.svh"

module grcm_checker
   import grcm_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire grcm_req_type              req_data,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire grcm_rsp_type              rsp_data
);

   // reset leaves no result and starts the clearing sweep
   `GRCM_ASSERT_NOW(a_reset_idle, $past(reset), !rsp_valid && !req_ready, "busy after reset")

   // a fresh result comes only from an accepted read beat
   `GRCM_ASSERT_NOW(a_rsp_from_read, $rose(rsp_valid),
      $past(req_valid && req_ready && (req_data.op == OP_READ), 2), "result without read")

   // a read beat blocks the next cycle
   `GRCM_ASSERT_NEXT(a_read_blocks, req_valid && req_ready && (req_data.op == OP_READ),
      !req_ready, "beat taken right behind a read")

   // a stalled result holds
   `GRCM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data),
      "stalled result changed")

endmodule

bind grid_root_condition_merge grcm_checker u_grcm_checker (.*);

`default_nettype wire
